>>> rtl/core/dtdg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtdg_pkg
// Shared types, constants and the sine table of the dual-tone DDS generator.
// ----------------------------------------------------------------------------
package dtdg_pkg;

  localparam int STEP_W  = 16;
  localparam int DUR_W   = 24;
  localparam int LEVEL_W = 8;
  localparam int SINE_AW = 8;
  localparam int HALF_W  = LEVEL_W - 1;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_TONES   = 2'd1,
    ACT_SILENCE = 2'd2
  } action_e;

  typedef struct packed {
    logic advance;
    logic load_step;
    logic clear;
  } tone_ctrl_t;

  localparam logic [6:0] QUARTER_WAVE [0:64] = '{
    7'd0,   7'd3,   7'd6,   7'd9,   7'd12,  7'd16,  7'd19,  7'd22,
    7'd25,  7'd28,  7'd31,  7'd34,  7'd37,  7'd40,  7'd43,  7'd46,
    7'd49,  7'd51,  7'd54,  7'd57,  7'd60,  7'd63,  7'd65,  7'd68,
    7'd71,  7'd73,  7'd76,  7'd78,  7'd81,  7'd83,  7'd85,  7'd88,
    7'd90,  7'd92,  7'd94,  7'd96,  7'd98,  7'd100, 7'd102, 7'd104,
    7'd106, 7'd107, 7'd109, 7'd111, 7'd112, 7'd113, 7'd115, 7'd116,
    7'd117, 7'd118, 7'd120, 7'd121, 7'd122, 7'd122, 7'd123, 7'd124,
    7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd127, 7'd127, 7'd127,
    7'd127
  };

  localparam logic [LEVEL_W-1:0] MID_LEVEL = 8'd128;

  // Full sine wave from the quarter table: 128 +/- quarter, range 1..255.
  function automatic logic [LEVEL_W-1:0] sine_lookup(input logic [SINE_AW-1:0] idx);
    logic [LEVEL_W-1:0] res;
    logic [SINE_AW:0]   wide;
    wide = {1'b0, idx};
    if (wide <= 9'd64) begin
      res = MID_LEVEL + {1'b0, QUARTER_WAVE[7'(idx)]};
    end else if (wide <= 9'd128) begin
      res = MID_LEVEL + {1'b0, QUARTER_WAVE[7'(9'd128 - wide)]};
    end else if (wide <= 9'd192) begin
      res = MID_LEVEL - {1'b0, QUARTER_WAVE[7'(wide - 9'd128)]};
    end else begin
      res = MID_LEVEL - {1'b0, QUARTER_WAVE[7'(9'd256 - wide)]};
    end
    return res;
  endfunction

endpackage

>>> rtl/core/dtdg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtdg_in_if / dtdg_out_if
// Valid/ready channels for commands and sample ticks in, levels out.
// ----------------------------------------------------------------------------
interface dtdg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] step_a;
  logic [15:0] step_b;
  logic [23:0] duration;

  modport source (output valid, output action, output step_a, output step_b,
                  output duration, input ready);
  modport sink   (input valid, input action, input step_a, input step_b,
                  input duration, output ready);
endinterface

interface dtdg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] level;
  logic       active;
  logic       rejected;

  modport source (output valid, output level, output active, output rejected,
                  input ready);
  modport sink   (input valid, input level, input active, input rejected,
                  output ready);
endinterface

>>> rtl/core/dtdg_tone.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtdg_tone
// One tone voice: phase step, phase accumulator and halved sine lookup.
// ----------------------------------------------------------------------------
module dtdg_tone #(
  parameter int PHASE_BITS      = 16,
  parameter int TABLE_ADDR_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dtdg_pkg::tone_ctrl_t        ctrl_i,
  input  logic [dtdg_pkg::STEP_W-1:0] step_i,
  output logic [dtdg_pkg::HALF_W-1:0] half_o
);
  import dtdg_pkg::*;

  localparam int SumW     = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;
  localparam int KeepBits = (TABLE_ADDR_BITS < SINE_AW) ? TABLE_ADDR_BITS : SINE_AW;

  logic [PHASE_BITS-1:0] phase_q, phase_d, phase_next, inc_p;
  logic [STEP_W-1:0]     inc_q, inc_d;
  logic [SumW-1:0]       inc_wide;
  logic [KeepBits-1:0]   top_bits;
  logic [SINE_AW-1:0]    idx;
  logic [LEVEL_W-1:0]    sine;

  assign inc_wide   = SumW'(inc_q);
  assign inc_p      = inc_wide[PHASE_BITS-1:0];
  assign phase_next = phase_q + inc_p;

  // top address bits, scaled to the 256-entry table
  assign top_bits = phase_next[PHASE_BITS-1 -: KeepBits];
  assign idx      = SINE_AW'(top_bits) << (SINE_AW - KeepBits);
  assign sine     = sine_lookup(idx);
  assign half_o   = sine[LEVEL_W-1:1];

  always_comb begin
    phase_d = phase_q;
    inc_d   = inc_q;
    if (ctrl_i.clear) begin
      phase_d = '0;
      inc_d   = '0;
    end else if (ctrl_i.load_step) begin
      inc_d = step_i;
    end else if (ctrl_i.advance) begin
      phase_d = phase_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      inc_q   <= '0;
    end else begin
      phase_q <= phase_d;
      inc_q   <= inc_d;
    end
  end

endmodule

>>> rtl/core/dtdg_burst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtdg_burst_ctrl
// Burst counter, run flag and held level; decodes commands for both voices.
// ----------------------------------------------------------------------------
module dtdg_burst_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fire_i,
  input  logic [1:0]                   action_i,
  input  logic [dtdg_pkg::DUR_W-1:0]   duration_i,
  input  logic [dtdg_pkg::HALF_W-1:0]  half_a_i,
  input  logic [dtdg_pkg::HALF_W-1:0]  half_b_i,
  output dtdg_pkg::tone_ctrl_t         tone_ctrl_o,
  output logic [dtdg_pkg::LEVEL_W-1:0] level_o,
  output logic                         active_o,
  output logic                         rejected_o
);
  import dtdg_pkg::*;

  logic [DUR_W-1:0]   samples_q, samples_d;
  logic               running_q, running_d;
  logic [LEVEL_W-1:0] held_q, held_d, level_new;
  logic               is_tick, is_cmd, is_tones, advance, start;

  always_comb begin
    is_tick  = 1'b0;
    is_cmd   = 1'b0;
    is_tones = 1'b0;
    case (action_i)
      ACT_TICK:    is_tick = 1'b1;
      ACT_TONES: begin
        is_cmd   = 1'b1;
        is_tones = 1'b1;
      end
      ACT_SILENCE: is_cmd = 1'b1;
      default:     ;
    endcase
  end

  assign level_new = LEVEL_W'(half_a_i) + LEVEL_W'(half_b_i);
  assign advance   = fire_i && is_tick && running_q;
  assign start     = fire_i && is_cmd && !running_q && (duration_i != '0);

  assign tone_ctrl_o.advance   = advance;
  assign tone_ctrl_o.load_step = start && is_tones;
  assign tone_ctrl_o.clear     = start && !is_tones;

  always_comb begin
    samples_d = samples_q;
    running_d = running_q;
    held_d    = held_q;
    if (advance) begin
      samples_d = samples_q - DUR_W'(1);
      running_d = (samples_q != DUR_W'(1));
      held_d    = level_new;
    end else if (start) begin
      samples_d = duration_i;
      running_d = 1'b1;
    end
  end

  assign level_o    = held_d;
  assign active_o   = running_d;
  assign rejected_o = is_cmd && running_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samples_q <= '0;
      running_q <= 1'b0;
      held_q    <= '0;
    end else begin
      samples_q <= samples_d;
      running_q <= running_d;
      held_q    <= held_d;
    end
  end

endmodule

>>> rtl/core/dual_tone_dds_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_tone_dds_generator_top
// Two-tone DDS producing a PWM compare level from sample ticks and commands.
// ----------------------------------------------------------------------------
// One transaction is taken per clock cycle while the output is not stalled,
// and every transaction returns exactly one result: an input register, then
// a stage that advances both phase accumulators, looks up the sine table and
// sums the halved values, then the result register. A full result register
// stalls the input side only when the input register is also full and the
// output is not being drained. Commands sent while a burst runs come back
// with rejected set; zero-length bursts are ignored. Phase steps and burst
// lengths are given in accumulator units and sample ticks.
module dual_tone_dds_generator_top #(
  parameter int PHASE_BITS      = 16,
  parameter int TABLE_ADDR_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dtdg_in_if.sink    in_i,
  dtdg_out_if.source out_o
);
  import dtdg_pkg::*;

  logic               s1_valid_q, s1_valid_d;
  logic [1:0]         action_q;
  logic [STEP_W-1:0]  step_a_q, step_b_q;
  logic [DUR_W-1:0]   duration_q;
  logic               out_valid_q, out_valid_d;
  logic [LEVEL_W-1:0] level_q, level_d;
  logic               active_q, active_d, rejected_q, rejected_d;
  logic               out_free, fire, in_accept;
  logic [HALF_W-1:0]  half_a, half_b;
  tone_ctrl_t         tone_ctrl;

  assign out_free  = !out_valid_q || out_o.ready;
  assign fire      = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_accept = in_i.valid && in_i.ready;

  assign s1_valid_d  = in_accept ? 1'b1 : (fire ? 1'b0 : s1_valid_q);
  assign out_valid_d = fire ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      action_q   <= in_i.action;
      step_a_q   <= in_i.step_a;
      step_b_q   <= in_i.step_b;
      duration_q <= in_i.duration;
    end
    if (fire) begin
      level_q    <= level_d;
      active_q   <= active_d;
      rejected_q <= rejected_d;
    end
  end

  dtdg_tone #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_tone_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (tone_ctrl),
    .step_i (step_a_q),
    .half_o (half_a)
  );

  dtdg_tone #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_tone_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (tone_ctrl),
    .step_i (step_b_q),
    .half_o (half_b)
  );

  dtdg_burst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .action_i    (action_q),
    .duration_i  (duration_q),
    .half_a_i    (half_a),
    .half_b_i    (half_b),
    .tone_ctrl_o (tone_ctrl),
    .level_o     (level_d),
    .active_o    (active_d),
    .rejected_o  (rejected_d)
  );

  assign out_o.valid    = out_valid_q;
  assign out_o.level    = level_q;
  assign out_o.active   = active_q;
  assign out_o.rejected = rejected_q;

endmodule

>>> rtl/core/dtdg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtdg_checker
// Port-level checks on the dual-tone DDS generator, bound to the top level.
// ----------------------------------------------------------------------------
module dtdg_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_level_i,
  input logic       out_active_i,
  input logic       out_rejected_i
);

  // a pending result must not disappear or change its level
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_level_i))
    else $error("result transaction dropped or changed while stalled");

  // sum of two halved sine values never exceeds 254
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_level_i != 8'd255)
    else $error("level out of range");

  // a rejected command leaves the running burst in place
  a_reject_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_rejected_i |-> out_active_i)
    else $error("rejected command reported with burst idle");

  // with the result register empty the input side is never stalled
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

endmodule

bind dual_tone_dds_generator_top dtdg_checker u_dtdg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_level_i    (out_o.level),
  .out_active_i   (out_o.active),
  .out_rejected_i (out_o.rejected)
);
